// ===== design/cofl_pkg.sv =====
// Shared types, constants and the gamma table for the center-out fill LED effect.
// Used by every module in this design; depends on nothing else.

package cofl_pkg;

  // Field and register widths
  localparam int NOW_W    = 32;
  localparam int IDX_W    = 5;
  localparam int LVL_W    = 8;
  localparam int SPEED_W  = 16;
  localparam int TAIL_W   = 13;
  localparam int PER_W    = 16;
  localparam int RAD_W    = 24;
  localparam int TAILX_W  = TAIL_W + 8;       // tail in Q5.16 units
  localparam int SQ_W     = 2 * TAILX_W;      // squared tail or offset
  localparam int DIVD_W   = SQ_W + 8;         // 255*den2 + den2/2 stays below 2^50
  localparam int PROD_W   = SPEED_W + NOW_W;  // speed times elapsed ms
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Default LED strip length
  localparam int LED_COUNT_DEF = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAXLVL = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 8'd3;

  // Register reset values
  localparam logic [SPEED_W-1:0] SPEED_RST  = 16'd393;
  localparam logic [TAIL_W-1:0]  TAIL_RST   = 13'd640;
  localparam logic [LVL_W-1:0]   MAXLVL_RST = 8'd200;
  localparam logic [PER_W-1:0]   PERIOD_RST = 16'd200;

  localparam logic [LVL_W-1:0] LVL_FULL = 8'd255;
  localparam logic [LVL_W-1:0] LVL_DARK = 8'd0;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;     // latch the input word, compute elapsed ms
    logic mul;        // speed times elapsed
    logic grow;       // add growth to radius, saturate
    logic check;      // switch to blink once past centre plus tail
    logic blink;      // blink timing, clear LED counter
    logic pix;        // classify current LED
    logic sq;         // square offset and tail
    logic diff;       // tail^2 - offset^2
    logic div_start;  // load dividend into divider
    logic lvl;        // gamma lookup and max_level scaling
    logic out_load;   // push result word into output register
    logic led_next;   // advance LED counter
    logic go_steady;  // enter steady mode, restart LED counter
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic need_div;   // current LED lies in the soft tail
    logic div_done;   // quotient ready
    logic out_free;   // output register can take a word
    logic last_led;   // counter at the final LED
    logic extra;      // blinking with remote online
  } sts_t;

  // Gamma table, G[k] = largest g with g==0 or (2g-1)^11 <= 2^11 * k^5 * 255^6
  typedef logic [255:0][7:0] gamma_t;

  function automatic gamma_t build_gamma();
    gamma_t       tab;
    logic [127:0] lhs;
    logic [127:0] rhs;
    int           g;
    g   = 0;
    tab = '0;
    for (int k = 0; k < 256; k++) begin
      rhs = 128'd2048;
      for (int j = 0; j < 5; j++) rhs = rhs * 128'(k);
      for (int j = 0; j < 6; j++) rhs = rhs * 128'd255;
      while (g < 255) begin
        lhs = 128'd1;
        for (int j = 0; j < 11; j++) lhs = lhs * 128'(2 * g + 1);
        if (lhs <= rhs) g++;
        else break;
      end
      tab[k] = 8'(g);
    end
    return tab;
  endfunction

  localparam gamma_t GAMMA = build_gamma();

endpackage

// ===== design/center_out_fill_led_effect.sv =====
// Per tick: state update (elapsed time, growth, mode check, blink timing), then one word
// per LED via classify, lookup and scale, emit; soft-tail LEDs also pass the 8-step divider.
// Each tick yields one frame, or two frames when blinking with the remote online;
// the next tick is taken once the last word enters the output register.
// Reset (rst_n, synchronous): registers to defaults, expand mode, zero radius.
// Depends on cofl_pkg, cofl_ctrl and cofl_dp.

module center_out_fill_led_effect #(
  parameter int LED_COUNT = cofl_pkg::LED_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Tick input
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,   // [31:0] now_ms
  input  logic                              in_tuser,   // [0] remote_online
  // Configuration write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cofl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cofl_pkg::CFG_DATA_W-1:0]   cfg_data,
  // LED results
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [15:0]                       out_tdata,  // [4:0] led_index, [12:5] level
  output logic                              out_tlast   // last_of_frame
);

  cofl_pkg::cmd_t cmd;
  cofl_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  cofl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  cofl_dp #(
    .LED_COUNT (LED_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== design/cofl_div.sv =====
// Restoring divider for the tail intensity: one quotient bit per cycle, 8 bits.
// Depends on cofl_pkg for widths.

module cofl_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [cofl_pkg::DIVD_W-1:0]   dividend,
  input  logic [cofl_pkg::SQ_W-1:0]     divisor,
  output logic                          done,
  output logic [cofl_pkg::LVL_W-1:0]    quotient
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [2:0]                    cnt_r, cnt_nxt;
  logic [cofl_pkg::DIVD_W-1:0]   rem_r, rem_nxt;
  logic [cofl_pkg::DIVD_W-1:0]   dsh_r, dsh_nxt;
  logic [cofl_pkg::LVL_W-1:0]    quo_r, quo_nxt;
  logic                          ge;

  assign ge = (rem_r >= dsh_r);

  // Step: compare, subtract, shift divisor down
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd7;
      rem_nxt  = dividend;
      dsh_nxt  = {1'b0, divisor, 7'b0};
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (ge) rem_nxt = rem_r - dsh_r;
      quo_nxt = {quo_r[cofl_pkg::LVL_W-2:0], ge};
      dsh_nxt = {1'b0, dsh_r[cofl_pkg::DIVD_W-1:1]};
      cnt_nxt = cnt_r - 3'd1;
      if (cnt_r == 3'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== design/cofl_dp.sv =====
// Datapath: configuration registers, effect state, per-LED intensity and level,
// output word register. Depends on cofl_pkg and cofl_div.

module cofl_dp #(
  parameter int LED_COUNT = cofl_pkg::LED_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cofl_pkg::cmd_t                    cmd,
  output cofl_pkg::sts_t                    sts,
  input  logic [31:0]                       in_tdata,
  input  logic                              in_tuser,
  input  logic                              cfg_valid,
  input  logic [cofl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cofl_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [15:0]                       out_tdata,
  output logic                              out_tlast
);

  typedef enum logic [1:0] {
    MODE_EXPAND = 2'd0,
    MODE_BLINK  = 2'd1,
    MODE_STEADY = 2'd2
  } mode_t;

  localparam int IDX_W  = cofl_pkg::IDX_W;
  localparam int RAD_W  = cofl_pkg::RAD_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);
  localparam logic [IDX_W:0]   NM1      = (IDX_W + 1)'(LED_COUNT - 1);
  localparam logic [RAD_W:0]   MID      = (RAD_W + 1)'((LED_COUNT - 1) * 32768);

  // Configuration
  logic [cofl_pkg::SPEED_W-1:0] spd_r;
  logic [cofl_pkg::TAIL_W-1:0]  tail_r;
  logic [cofl_pkg::LVL_W-1:0]   maxl_r;
  logic [cofl_pkg::PER_W-1:0]   per_r;

  // Effect state
  mode_t                        mode_r;
  logic [RAD_W-1:0]             rad_r;
  logic [cofl_pkg::NOW_W-1:0]   prev_r;
  logic [cofl_pkg::NOW_W-1:0]   mark_r;
  logic                         lit_r;

  // Working registers
  logic [cofl_pkg::NOW_W-1:0]   now_r;
  logic                         online_r;
  logic [cofl_pkg::NOW_W-1:0]   dt_r;
  logic [cofl_pkg::PROD_W-1:0]  prod_r;
  logic [IDX_W-1:0]             idx_r;
  logic [cofl_pkg::TAILX_W-1:0] num_r;
  logic [cofl_pkg::SQ_W-1:0]    num2_r;
  logic [cofl_pkg::SQ_W-1:0]    den2_r;
  logic [cofl_pkg::SQ_W-1:0]    diff_r;
  logic [cofl_pkg::LVL_W-1:0]   q_r;
  logic [15:0]                  lvp_r;

  // Output register
  logic                         ovld_r;
  logic [IDX_W-1:0]             oidx_r;
  logic [cofl_pkg::LVL_W-1:0]   olvl_r;
  logic                         olast_r;

  // Combinational helpers
  logic [cofl_pkg::NOW_W-1:0]   now_in;
  logic [RAD_W+cofl_pkg::PROD_W-RAD_W:0] grow_sum;
  logic [cofl_pkg::TAILX_W-1:0] tailx;
  logic [IDX_W:0]               two_i;
  logic [IDX_W:0]               dabs;
  logic [RAD_W-1:0]             led_dist;
  logic [RAD_W-1:0]             dmr;
  logic                         beyond;
  logic                         in_tail;
  logic [cofl_pkg::LVL_W-1:0]   q_sel;
  logic [cofl_pkg::NOW_W-1:0]   mark_eff;
  logic [cofl_pkg::NOW_W-1:0]   elapsed;
  logic [cofl_pkg::DIVD_W-1:0]  dividend;
  logic                         div_done;
  logic [cofl_pkg::LVL_W-1:0]   div_q;
  logic [15:0]                  lvl_adj;

  assign now_in   = in_tdata[cofl_pkg::NOW_W-1:0];
  assign grow_sum = {{(cofl_pkg::PROD_W-RAD_W+1){1'b0}}, rad_r} + {1'b0, prod_r};
  assign tailx    = {tail_r, 8'b0};

  // Distance of current LED from the strip centre
  assign two_i = {idx_r, 1'b0};
  assign dabs  = (two_i >= NM1) ? (two_i - NM1) : (NM1 - two_i);
  assign led_dist = {{(RAD_W-IDX_W-15){1'b0}}, dabs[IDX_W-1:0], 15'b0};
  assign dmr   = led_dist - rad_r;
  assign beyond  = (led_dist > rad_r);
  assign in_tail = beyond && (dmr <= {{(RAD_W-cofl_pkg::TAILX_W){1'b0}}, tailx})
                   && (tail_r != '0);

  // Intensity of LEDs that need no division
  always_comb begin
    case (mode_r)
      MODE_EXPAND: q_sel = beyond ? cofl_pkg::LVL_DARK : cofl_pkg::LVL_FULL;
      MODE_BLINK:  q_sel = lit_r ? cofl_pkg::LVL_FULL : cofl_pkg::LVL_DARK;
      default:     q_sel = cofl_pkg::LVL_FULL;
    endcase
  end

  // Blink timing, an unset mark takes the current time
  assign mark_eff = (mark_r == '0) ? now_r : mark_r;
  assign elapsed  = now_r - mark_eff;

  // 255*(den2-num2) + den2/2
  assign dividend = {diff_r, 8'b0} - {8'b0, diff_r} + {9'b0, den2_r[cofl_pkg::SQ_W-1:1]};

  cofl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (den2_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Divide by 255, exact for values below 65280
  assign lvl_adj = lvp_r + {8'b0, lvp_r[15:8]} + 16'd1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_r  <= cofl_pkg::SPEED_RST;
      tail_r <= cofl_pkg::TAIL_RST;
      maxl_r <= cofl_pkg::MAXLVL_RST;
      per_r  <= cofl_pkg::PERIOD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        cofl_pkg::REG_SPEED:  spd_r  <= cfg_data[cofl_pkg::SPEED_W-1:0];
        cofl_pkg::REG_TAIL:   tail_r <= cfg_data[cofl_pkg::TAIL_W-1:0];
        cofl_pkg::REG_MAXLVL: maxl_r <= cfg_data[cofl_pkg::LVL_W-1:0];
        cofl_pkg::REG_PERIOD: per_r  <= cfg_data[cofl_pkg::PER_W-1:0];
        default: ;
      endcase
    end
  end

  // Effect state and control-side registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_EXPAND;
      rad_r  <= '0;
      prev_r <= '0;
      mark_r <= '0;
      lit_r  <= 1'b0;
      idx_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      if (cmd.accept) prev_r <= now_in;
      // Saturating radius growth
      if (cmd.grow && mode_r == MODE_EXPAND) begin
        if (|grow_sum[RAD_W+cofl_pkg::PROD_W-RAD_W:RAD_W]) rad_r <= '1;
        else rad_r <= grow_sum[RAD_W-1:0];
      end
      // Enter blink once the radius passes centre plus tail
      if (cmd.check && mode_r == MODE_EXPAND &&
          {1'b0, rad_r} > (MID + {{(RAD_W+1-cofl_pkg::TAILX_W){1'b0}}, tailx})) begin
        mode_r <= MODE_BLINK;
        rad_r  <= MID[RAD_W-1:0];
      end
      // Toggle on period expiry, restart LED counter
      if (cmd.blink) begin
        idx_r <= '0;
        if (mode_r == MODE_BLINK) begin
          if (elapsed >= {{(cofl_pkg::NOW_W-cofl_pkg::PER_W){1'b0}}, per_r}) begin
            lit_r  <= ~lit_r;
            mark_r <= now_r;
          end else begin
            mark_r <= mark_eff;
          end
        end
      end
      if (cmd.go_steady) begin
        mode_r <= MODE_STEADY;
        idx_r  <= '0;
      end
      if (cmd.led_next) idx_r <= idx_r + IDX_W'(1);
      // Output word handshake
      if (cmd.out_load) ovld_r <= 1'b1;
      else if (out_tready) ovld_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      now_r    <= now_in;
      online_r <= in_tuser;
      dt_r     <= (prev_r != '0) ? (now_in - prev_r) : '0;
    end
    if (cmd.mul)  prod_r <= cofl_pkg::PROD_W'(spd_r) * cofl_pkg::PROD_W'(dt_r);
    if (cmd.pix) begin
      q_r   <= q_sel;
      num_r <= dmr[cofl_pkg::TAILX_W-1:0];
    end
    if (cmd.sq) begin
      num2_r <= cofl_pkg::SQ_W'(num_r) * cofl_pkg::SQ_W'(num_r);
      den2_r <= {cofl_pkg::SQ_W'(tail_r) * cofl_pkg::SQ_W'(tail_r)} << 16;
    end
    if (cmd.diff) diff_r <= den2_r - num2_r;
    if (div_done) q_r <= div_q;
    if (cmd.lvl)  lvp_r <= 16'(cofl_pkg::GAMMA[q_r]) * 16'(maxl_r) + 16'd127;
    if (cmd.out_load) begin
      oidx_r  <= idx_r;
      olvl_r  <= lvl_adj[15:8];
      olast_r <= (idx_r == LAST_IDX);
    end
  end

  assign sts.need_div = (mode_r == MODE_EXPAND) && in_tail;
  assign sts.div_done = div_done;
  assign sts.out_free = !ovld_r || out_tready;
  assign sts.last_led = (idx_r == LAST_IDX);
  assign sts.extra    = (mode_r == MODE_BLINK) && online_r;

  assign out_tvalid = ovld_r;
  assign out_tdata  = {3'b0, olvl_r, oidx_r};
  assign out_tlast  = olast_r;

endmodule

// ===== design/cofl_ctrl.sv =====
// Controller state machine: sequences one tick through state update and the
// per-LED loop. Depends on cofl_pkg for the command and status structs.

module cofl_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output cofl_pkg::cmd_t  cmd,
  input  cofl_pkg::sts_t  sts
);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_MUL   = 12'b000000000010,
    ST_GROW  = 12'b000000000100,
    ST_CHECK = 12'b000000001000,
    ST_BLINK = 12'b000000010000,
    ST_PIX   = 12'b000000100000,
    ST_SQ    = 12'b000001000000,
    ST_DIFF  = 12'b000010000000,
    ST_LOAD  = 12'b000100000000,
    ST_DIV   = 12'b001000000000,
    ST_LVL   = 12'b010000000000,
    ST_EMIT  = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_GROW;
      end
      ST_GROW: begin
        cmd.grow  = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = ST_BLINK;
      end
      ST_BLINK: begin
        cmd.blink = 1'b1;
        state_nxt = ST_PIX;
      end
      ST_PIX: begin
        cmd.pix   = 1'b1;
        state_nxt = sts.need_div ? ST_SQ : ST_LVL;
      end
      ST_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_LVL;
      end
      ST_LVL: begin
        cmd.lvl   = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // Hold until the output register frees, then advance, start the steady frame or end the frame
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (!sts.last_led) begin
            cmd.led_next = 1'b1;
            state_nxt    = ST_PIX;
          end else if (sts.extra) begin
            cmd.go_steady = 1'b1;
            state_nxt     = ST_PIX;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule
